### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the ACL checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### rtl/acl_pkg.sv
// ---------------------------------------------------------------------------
// acl_pkg
// Types and constants of the access control list checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package acl_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ID_W          = 32;
  localparam int RIGHTS_W      = 3;
  localparam int SLOT_W        = 8;
  localparam int OP_W          = 2;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_DATA_W     = 80;
  localparam int OUT_DATA_W    = 8;

  localparam logic [ID_W-1:0]  ID_WILDCARD = '1;
  localparam logic [CNT_W-1:0] TABLE_FULL  = CNT_W'(TABLE_ENTRIES);

  // Operation codes
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_OWNER_USER   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OWNING_GROUP = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OWNER_RIGHTS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUP_RIGHTS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OTHER_RIGHTS = 3'd4;

  // One table entry
  typedef struct packed {
    logic [ID_W-1:0]     user;
    logic [ID_W-1:0]     group;
    logic [RIGHTS_W-1:0] rights;
  } entry_t;

  // Table access request from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } tbl_req_t;

endpackage

### rtl/acl_table.sv
// ---------------------------------------------------------------------------
// acl_table
// Entry store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acl_table
  import acl_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/acl_cmp.sv
// ---------------------------------------------------------------------------
// acl_cmp
// Entry matcher: id match with wildcard and rights cover test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acl_cmp
  import acl_pkg::*;
(
  input  entry_t              entry,
  input  logic [ID_W-1:0]     uid,
  input  logic [ID_W-1:0]     gid,
  input  logic [RIGHTS_W-1:0] want,
  output logic                hit
);

  logic user_match;
  logic group_match;
  logic covers;

  // All-ones ids in an entry match anything
  assign user_match  = (entry.user == ID_WILDCARD) || (entry.user == uid);
  assign group_match = (entry.group == ID_WILDCARD) || (entry.group == gid);
  assign covers      = ((want & entry.rights) == want);
  assign hit         = user_match && group_match && covers;

endmodule

### rtl/access_control_list_checker.sv
// Each item runs through EXEC and DONE; a check that the base rights do not grant
// also walks the used table entries in SCAN, and a remove of a used entry other
// than the last shifts the entries above its slot down one place in SHIFT.
// One item at a time: the next item is accepted only after the result has gone to
// the output register; DONE waits while out_tready holds back the previous result.
// Synchronous active-low reset clears the count, sequencer and output valid and loads config reg defaults.
// ---------------------------------------------------------------------------
// access_control_list_checker
// Owner/group/other permission check with an extra table of grant entries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module access_control_list_checker
  import acl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] user_id, [63:32] group_id, [66:64] rights, [74:67] slot, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]       in_tuser,
  // Result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] allowed, [1] status, [6:2] entries_used, [7] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Configuration registers
  logic [ID_W-1:0]     owner_user_r, owner_user_nxt;
  logic [ID_W-1:0]     owning_group_r, owning_group_nxt;
  logic [RIGHTS_W-1:0] owner_rights_r, owner_rights_nxt;
  logic [RIGHTS_W-1:0] group_rights_r, group_rights_nxt;
  logic [RIGHTS_W-1:0] other_rights_r, other_rights_nxt;

  // Item fields
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [ID_W-1:0]     uid_r, uid_nxt;
  logic [ID_W-1:0]     gid_r, gid_nxt;
  logic [RIGHTS_W-1:0] want_r, want_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  // Working state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             allowed_r, allowed_nxt;
  logic             status_r, status_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  tbl_req_t         tbl_req;
  entry_t           rd_data;
  logic             hit;
  logic [RIGHTS_W-1:0] base_rights;
  logic             base_ok;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] slot_inc;
  logic             in_fire;
  logic             cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Table matcher for the scan step
  acl_cmp u_cmp (
    .entry (rd_data),
    .uid   (uid_r),
    .gid   (gid_r),
    .want  (want_r),
    .hit   (hit)
  );

  // Entry store
  acl_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (rd_data)
  );

  // Base rights by precedence: owner, then group, then other
  always_comb begin
    priority if (uid_r == owner_user_r) begin
      base_rights = owner_rights_r;
    end else if (gid_r == owning_group_r) begin
      base_rights = group_rights_r;
    end else begin
      base_rights = other_rights_r;
    end
  end

  assign base_ok  = ((want_r & base_rights) == want_r);
  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_dec  = idx_r - CNT_W'(1);
  assign slot_inc = CNT_W'(slot_r[IDX_W-1:0]) + CNT_W'(1);

  // Configuration write decode
  always_comb begin
    owner_user_nxt   = owner_user_r;
    owning_group_nxt = owning_group_r;
    owner_rights_nxt = owner_rights_r;
    group_rights_nxt = group_rights_r;
    other_rights_nxt = other_rights_r;
    if (cfg_fire) begin
      unique case (cfg_addr)
        REG_OWNER_USER:   owner_user_nxt   = cfg_data;
        REG_OWNING_GROUP: owning_group_nxt = cfg_data;
        REG_OWNER_RIGHTS: owner_rights_nxt = cfg_data[RIGHTS_W-1:0];
        REG_GROUP_RIGHTS: group_rights_nxt = cfg_data[RIGHTS_W-1:0];
        REG_OTHER_RIGHTS: other_rights_nxt = cfg_data[RIGHTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    uid_nxt       = uid_r;
    gid_nxt       = gid_r;
    want_nxt      = want_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    allowed_nxt   = allowed_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    tbl_req       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_tuser;
          uid_nxt     = in_tdata[31:0];
          gid_nxt     = in_tdata[63:32];
          want_nxt    = in_tdata[66:64];
          slot_nxt    = in_tdata[74:67];
          allowed_nxt = 1'b0;
          status_nxt  = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (op_r)
          OP_CHECK: begin
            if (base_ok) begin
              allowed_nxt = 1'b1;
            end else if (cnt_r != '0) begin
              // Start the walk at entry 0
              tbl_req.rd_en   = 1'b1;
              tbl_req.rd_addr = '0;
              idx_nxt         = CNT_W'(1);
              state_nxt       = ST_SCAN;
            end
          end
          OP_ADD: begin
            if (cnt_r == TABLE_FULL) begin
              status_nxt = 1'b1;
            end else begin
              tbl_req.wr_en   = 1'b1;
              tbl_req.wr_addr = cnt_r[IDX_W-1:0];
              tbl_req.wr_data = '{user: uid_r, group: gid_r, rights: want_r};
              cnt_nxt         = cnt_r + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            if (slot_r >= SLOT_W'(cnt_r)) begin
              status_nxt = 1'b1;
            end else if (slot_inc == cnt_r) begin
              // Last entry: nothing to shift
              cnt_nxt = cnt_r - CNT_W'(1);
            end else begin
              tbl_req.rd_en   = 1'b1;
              tbl_req.rd_addr = slot_inc[IDX_W-1:0];
              idx_nxt         = slot_inc;
              state_nxt       = ST_SHIFT;
            end
          end
          OP_CLEAR: begin
            cnt_nxt = '0;
          end
          default: ;
        endcase
      end

      // Entry idx_r - 1 is on the read port
      ST_SCAN: begin
        if (hit) begin
          allowed_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else if (idx_r == cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = idx_r[IDX_W-1:0];
          idx_nxt         = idx_inc;
        end
      end

      // Entry idx_r is on the read port; move it down one place
      ST_SHIFT: begin
        tbl_req.wr_en   = 1'b1;
        tbl_req.wr_addr = idx_dec[IDX_W-1:0];
        tbl_req.wr_data = rd_data;
        if (idx_inc == cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = idx_inc[IDX_W-1:0];
          idx_nxt         = idx_inc;
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cnt_r, status_r, allowed_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      owner_user_r   <= '0;
      owning_group_r <= '0;
      owner_rights_r <= 3'd7;
      group_rights_r <= 3'd5;
      other_rights_r <= 3'd5;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
      owner_user_r   <= owner_user_nxt;
      owning_group_r <= owning_group_nxt;
      owner_rights_r <= owner_rights_nxt;
      group_rights_r <= group_rights_nxt;
      other_rights_r <= other_rights_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    uid_r      <= uid_nxt;
    gid_r      <= gid_nxt;
    want_r     <= want_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
    allowed_r  <= allowed_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > TABLE_FULL, "entry count above table size")
  `ASSERT_NEVER(a_scan_idx, clk, rst_n, (state_r == ST_SCAN) && ((idx_r == '0) || (idx_r > cnt_r)), "scan index out of range")
  `ASSERT_NEVER(a_scan_nowr, clk, rst_n, (state_r == ST_SCAN) && tbl_req.wr_en, "table written during a check")
  `ASSERT_NEVER(a_shift_wr, clk, rst_n, (state_r == ST_SHIFT) && (CNT_W'(tbl_req.wr_addr) >= cnt_r), "shift writes beyond the used entries")
  `ASSERT_PROP(a_out_src, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_DONE), "result raised outside the done step")

endmodule
